>>> rtl/srr_pkg.sv
// Shared constants, types and helpers for the stepper ramp reversal controller.
// No dependencies; imported by the interfaces and every module of the block.
`timescale 1ns / 1ps

package srr_pkg;

    localparam int DELAY_WIDTH    = 16;
    localparam int PRESCALE_WIDTH = 8;
    localparam int CFG_DATA_W     = (DELAY_WIDTH > PRESCALE_WIDTH) ? DELAY_WIDTH
                                                                   : PRESCALE_WIDTH;
    localparam int CFG_IDX_W      = 3;

    typedef logic [1:0]                t_dir;
    typedef logic [DELAY_WIDTH-1:0]    t_delay;
    typedef logic [PRESCALE_WIDTH-1:0] t_presc;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]     t_cfg_data;

    localparam t_dir DIR_STOP = 2'd0;
    localparam t_dir DIR_FWD  = 2'd1;
    localparam t_dir DIR_BWD  = 2'd2;
    localparam t_dir DIR_BAD  = 2'd3;

    localparam t_cfg_idx REG_CEIL_DELAY     = 3'd0;
    localparam t_cfg_idx REG_CRUISE_DELAY   = 3'd1;
    localparam t_cfg_idx REG_ACCEL_STEP     = 3'd2;
    localparam t_cfg_idx REG_DIVIDE_STEP    = 3'd3;
    localparam t_cfg_idx REG_REVERSE_WIRING = 3'd4;

    localparam t_delay RST_CEIL_DELAY    = t_delay'(2000);
    localparam t_delay RST_CRUISE_DELAY  = t_delay'(500);
    localparam t_delay RST_ACCEL_STEP    = t_delay'(10);
    localparam t_presc RST_DIVIDE_STEP   = t_presc'(3);

    typedef struct packed {
        t_delay ceil_delay;
        t_delay cruise_delay;
        t_delay accel_step;
        t_presc divide_step;
        logic   reverse_wiring;
    } t_ramp_cfg;

    typedef struct packed {
        t_dir   direction;
        t_delay half_period;
        t_presc prescale;
        logic   pin;
    } t_ramp_state;

    // Pin level for a motion code; stop drives low.
    function automatic logic dir_pin(input t_dir dir, input logic rev);
        logic lvl;
        lvl = 1'b0;
        if (dir == DIR_FWD) begin
            lvl = ~rev;
        end else if (dir == DIR_BWD) begin
            lvl = rev;
        end
        return lvl;
    endfunction

endpackage

>>> rtl/srr_in_if.sv
// Input channel of the ramp controller: valid/ready and the wanted direction.
// Depends on srr_pkg.
`timescale 1ns / 1ps

interface srr_in_if;
    import srr_pkg::*;

    logic valid;
    logic ready;
    t_dir wanted_direction;

    modport source (output valid, output wanted_direction, input ready);
    modport sink   (input valid, input wanted_direction, output ready);
endinterface

>>> rtl/srr_out_if.sv
// Result channel of the ramp controller: valid/ready and the step result fields.
// Depends on srr_pkg.
`timescale 1ns / 1ps

interface srr_out_if;
    import srr_pkg::*;

    logic   valid;
    logic   ready;
    logic   step_pulse;
    t_delay half_period_us;
    logic   direction_level;
    t_dir   running_direction;

    modport source (output valid, output step_pulse, output half_period_us,
                    output direction_level, output running_direction, input ready);
    modport sink   (input valid, input step_pulse, input half_period_us,
                    input direction_level, input running_direction, output ready);
endinterface

>>> rtl/srr_ramp_core.sv
// Next-state logic of the ramp: prescaler, half-period clamp and reversal.
// Depends on srr_pkg; purely combinational.
`timescale 1ns / 1ps

module srr_ramp_core (
    input  srr_pkg::t_ramp_state i_state,
    input  srr_pkg::t_ramp_cfg   i_cfg,
    input  srr_pkg::t_dir        i_wanted,
    output srr_pkg::t_ramp_state o_state,
    output logic                 o_pulse
);
    import srr_pkg::*;

    localparam int VW = DELAY_WIDTH + 2;

    t_dir                 wanted;
    t_dir                 dir_run;
    logic                 pin_run;
    logic                 reversing;
    logic                 ramp_down;
    t_presc               presc_inc;
    logic                 due;
    t_delay               adj;
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    t_delay               clamped;

    always_comb begin
        wanted    = (i_wanted == DIR_BAD) ? DIR_STOP : i_wanted;
        dir_run   = (i_state.direction == DIR_STOP) ? wanted : i_state.direction;
        pin_run   = (i_state.direction == DIR_STOP) ? dir_pin(wanted, i_cfg.reverse_wiring)
                                                    : i_state.pin;
        reversing = (dir_run != wanted);
        ramp_down = !reversing && (i_state.half_period != i_cfg.cruise_delay);

        presc_inc = i_state.prescale + t_presc'(1);
        due       = (presc_inc == i_cfg.divide_step);
        adj       = due ? i_cfg.accel_step : '0;

        if (reversing) begin
            v = $signed({2'b00, i_state.half_period}) + $signed({2'b00, adj});
        end else begin
            v = $signed({2'b00, i_state.half_period}) - $signed({2'b00, adj});
        end
        lo = $signed({2'b00, i_cfg.cruise_delay});
        hi = $signed({2'b00, i_cfg.ceil_delay});

        // Floor first: with an inverted window, values below the cruise delay take it, all others the ceiling.
        if (v < lo) begin
            clamped = i_cfg.cruise_delay;
        end else if (v > hi) begin
            clamped = i_cfg.ceil_delay;
        end else begin
            clamped = v[DELAY_WIDTH-1:0];
        end

        o_state = i_state;
        o_pulse = 1'b0;
        if (!(i_state.direction == DIR_STOP && wanted == DIR_STOP)) begin
            o_pulse           = 1'b1;
            o_state.direction = dir_run;
            o_state.pin       = pin_run;
            if (reversing || ramp_down) begin
                o_state.prescale    = due ? '0 : presc_inc;
                o_state.half_period = clamped;
            end
            if (reversing && clamped == i_cfg.ceil_delay) begin
                o_state.direction = wanted;
                o_state.pin       = dir_pin(wanted, i_cfg.reverse_wiring);
            end
        end
    end

endmodule

>>> rtl/stepper_ramp_reversal_controller_unit.sv
// Top level of the stepper ramp reversal controller: config registers, ramp
// state and result register. Depends on srr_pkg, srr_in_if, srr_out_if, srr_ramp_core.
`timescale 1ns / 1ps

// Use of the block
// - i_in carries one step tick per item with the wanted motion
//   (stop, forward, backward; the unused code counts as stop).
// - o_out returns exactly one result item per tick: step pulse flag,
//   half-period in microseconds, direction pin level and running motion.
// - i_cfg_we/i_cfg_index/i_cfg_data write the five ramp registers; write
//   them only while no tick is in flight. Unknown indexes are ignored.
// Timing and throughput
// - A result is registered and appears the cycle after its tick is accepted; one tick
//   per cycle is sustained unless the receiver stalls, set by the ramp state loop.
// Reset
// - Synchronous, active low: registers take their defaults, motion is stop,
//   half-period equals the default ceiling delay, prescaler and pin clear,
//   the result register empties.
// Stall
// - The result register is held while the receiver stalls; a new tick is
//   taken in the same cycle the held result leaves, so nothing is lost.

module stepper_ramp_reversal_controller_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    srr_in_if.sink              i_in,
    srr_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  srr_pkg::t_cfg_idx   i_cfg_index,
    input  srr_pkg::t_cfg_data  i_cfg_data
);
    import srr_pkg::*;

    t_ramp_cfg   r_cfg;
    t_ramp_state r_state;
    t_ramp_state n_state;
    logic        n_pulse;
    logic        accept;

    logic        r_out_valid;
    logic        r_out_pulse;
    t_delay      r_out_half;
    logic        r_out_pin;
    t_dir        r_out_dir;

    // Take a tick when the result slot is free or is being emptied now.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    srr_ramp_core u_core (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_wanted (i_in.wanted_direction),
        .o_state  (n_state),
        .o_pulse  (n_pulse)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ceil_delay     <= RST_CEIL_DELAY;
            r_cfg.cruise_delay   <= RST_CRUISE_DELAY;
            r_cfg.accel_step     <= RST_ACCEL_STEP;
            r_cfg.divide_step    <= RST_DIVIDE_STEP;
            r_cfg.reverse_wiring <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CEIL_DELAY:     r_cfg.ceil_delay     <= i_cfg_data[DELAY_WIDTH-1:0];
                REG_CRUISE_DELAY:   r_cfg.cruise_delay   <= i_cfg_data[DELAY_WIDTH-1:0];
                REG_ACCEL_STEP:     r_cfg.accel_step     <= i_cfg_data[DELAY_WIDTH-1:0];
                REG_DIVIDE_STEP:    r_cfg.divide_step    <= i_cfg_data[PRESCALE_WIDTH-1:0];
                REG_REVERSE_WIRING: r_cfg.reverse_wiring <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Ramp state: advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.direction   <= DIR_STOP;
            r_state.half_period <= RST_CEIL_DELAY;
            r_state.prescale    <= '0;
            r_state.pin         <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Result register: load on accept, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_pulse <= n_pulse;
            r_out_half  <= n_state.half_period;
            r_out_pin   <= n_state.pin;
            r_out_dir   <= n_state.direction;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.step_pulse        = r_out_pulse;
    assign o_out.half_period_us    = r_out_half;
    assign o_out.direction_level   = r_out_pin;
    assign o_out.running_direction = r_out_dir;

endmodule

>>> rtl/srr_checker.sv
// Port-level assertions for the ramp controller, bound to its top level.
// Depends on srr_pkg and stepper_ramp_reversal_controller_unit.
`timescale 1ns / 1ps

module srr_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic            i_out_pulse,
    input srr_pkg::t_delay i_out_half,
    input logic            i_out_pin,
    input srr_pkg::t_dir   i_out_dir
);
    import srr_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pulse)
            && $stable(i_out_half) && $stable(i_out_pin) && $stable(i_out_dir))
        else $error("stalled result changed");

    // Every accepted tick yields a result in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("result missing after accepted tick");

    // No tick is taken while a held result would be overwritten.
    a_noovr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("tick accepted over stalled result");

    // Any running motion comes with a step pulse.
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_dir != DIR_STOP |-> i_out_pulse)
        else $error("motion without step pulse");

    // Reset empties the result register.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind stepper_ramp_reversal_controller_unit srr_checker u_srr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pulse (o_out.step_pulse),
    .i_out_half  (o_out.half_period_us),
    .i_out_pin   (o_out.direction_level),
    .i_out_dir   (o_out.running_direction)
);
